### sv/crcdf_pkg.sv
// ----------------------------------------------------------------------------
// crcdf_pkg: shared types, constants and functions
// Item and result structs, header offsets, status codes and the bytewise
// reflected CRC-32 update used by the container deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

	// Byte counter width; the counter saturates at its all-ones value.
	localparam int POS_W = 34;
	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_MAGIC_END = pos_t'(4);
	localparam pos_t POS_VER_END   = pos_t'(6);
	localparam pos_t POS_KIND_END  = pos_t'(8);
	localparam pos_t POS_HDR_END   = pos_t'(12);
	localparam pos_t POS_MIN_FILE  = pos_t'(16);
	localparam pos_t POS_MAX       = '1;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SHORT   = 3'd1;
	localparam logic [2:0] ST_MAGIC   = 3'd2;
	localparam logic [2:0] ST_VERSION = 3'd3;
	localparam logic [2:0] ST_KIND    = 3'd4;
	localparam logic [2:0] ST_LENGTH  = 3'd5;
	localparam logic [2:0] ST_CRC     = 3'd6;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_KIND    = 8'd1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  payload_byte;
		logic [2:0]  status_code;
		logic [31:0] body_length;
	} result_t;

	// Magic "ITLP", first byte at index 0
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0:    m = 8'h49; // I
			2'd1:    m = 8'h54; // T
			2'd2:    m = 8'h4C; // L
			default: m = 8'h50; // P
		endcase
		return m;
	endfunction

	// One byte through the reflected CRC-32, LSB first
	function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### sv/crcdf_in_stage.sv
// ----------------------------------------------------------------------------
// crcdf_in_stage: input register
// Captures one byte transfer per cycle and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module crcdf_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  crcdf_pkg::item_t item_in,
	input  logic             take,
	output logic             valid_s1,
	output crcdf_pkg::item_t item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule

### sv/crcdf_parser.sv
// ----------------------------------------------------------------------------
// crcdf_parser: header capture, CRC and status
// Holds the per-file state, decides payload pass-through and builds the
// final status on the last byte, then clears itself for the next file.
// ----------------------------------------------------------------------------
module crcdf_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  crcdf_pkg::item_t   item,
	input  logic [15:0]        exp_version,
	input  logic [15:0]        exp_kind,
	output logic               res_valid,
	output crcdf_pkg::result_t res
);

	crcdf_pkg::pos_t pos_q, count;
	logic            magic_q, magic_d;
	logic [15:0]     version_q, version_d;
	logic [15:0]     kind_q, kind_d;
	logic [31:0]     len_q, len_d;
	logic [31:0]     crc_q, crc_d;
	logic [31:0]     stored_q, stored_d;
	logic            in_window;
	logic [2:0]      code;
	logic [7:0]      b;

	assign b = item.data;

	always_comb begin
		magic_d   = magic_q;
		version_d = version_q;
		kind_d    = kind_q;
		len_d     = len_q;
		if (pos_q < crcdf_pkg::POS_MAGIC_END) begin
			magic_d = magic_q && (b == crcdf_pkg::magic_byte(pos_q[1:0]));
		end else if (pos_q < crcdf_pkg::POS_VER_END) begin
			version_d = {version_q[7:0], b};
		end else if (pos_q < crcdf_pkg::POS_KIND_END) begin
			kind_d = {kind_q[7:0], b};
		end else if (pos_q < crcdf_pkg::POS_HDR_END) begin
			len_d = {len_q[23:0], b};
		end

		// bytes reach the CRC only after leaving the 4-byte trailer window
		crc_d    = (pos_q >= crcdf_pkg::POS_MAGIC_END) ?
			crcdf_pkg::crc_update(crc_q, stored_q[31:24]) : crc_q;
		stored_d = {stored_q[23:0], b};

		count = (pos_q == crcdf_pkg::POS_MAX) ? crcdf_pkg::POS_MAX : pos_q + 1'b1;

		in_window = (pos_q >= crcdf_pkg::POS_HDR_END) &&
			((pos_q - crcdf_pkg::POS_HDR_END) < {2'b00, len_q});

		if (count < crcdf_pkg::POS_MIN_FILE) begin
			code = crcdf_pkg::ST_SHORT;
		end else if (!magic_d) begin
			code = crcdf_pkg::ST_MAGIC;
		end else if (version_d != exp_version) begin
			code = crcdf_pkg::ST_VERSION;
		end else if (kind_d != exp_kind) begin
			code = crcdf_pkg::ST_KIND;
		end else if (({2'b00, len_d} + crcdf_pkg::POS_MIN_FILE) != count) begin
			code = crcdf_pkg::ST_LENGTH;
		end else if ((crc_d ^ crcdf_pkg::CRC_ONES) != stored_d) begin
			code = crcdf_pkg::ST_CRC;
		end else begin
			code = crcdf_pkg::ST_OK;
		end

		res_valid = item.last || in_window;
		if (item.last) begin
			res.is_status    = 1'b1;
			res.payload_byte = 8'd0;
			res.status_code  = code;
			res.body_length  = (code == crcdf_pkg::ST_OK) ? len_d : 32'd0;
		end else begin
			res.is_status    = 1'b0;
			res.payload_byte = b;
			res.status_code  = crcdf_pkg::ST_OK;
			res.body_length  = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			magic_q   <= 1'b1;
			version_q <= '0;
			kind_q    <= '0;
			len_q     <= '0;
			crc_q     <= crcdf_pkg::CRC_ONES;
			stored_q  <= '0;
		end else if (step) begin
			if (item.last) begin
				pos_q     <= '0;
				magic_q   <= 1'b1;
				version_q <= '0;
				kind_q    <= '0;
				len_q     <= '0;
				crc_q     <= crcdf_pkg::CRC_ONES;
				stored_q  <= '0;
			end else begin
				pos_q     <= count;
				magic_q   <= magic_d;
				version_q <= version_d;
				kind_q    <= kind_d;
				len_q     <= len_d;
				crc_q     <= crc_d;
				stored_q  <= stored_d;
			end
		end
	end

endmodule

### sv/crc32_container_deframer.sv
// ----------------------------------------------------------------------------
// crc32_container_deframer: container file deframer with CRC-32 check
// Top level: input register, parser, result register, config registers.
// ----------------------------------------------------------------------------
// The block takes a container file one byte per transfer, last_byte set on
// the final byte, and sustains one byte per clock cycle while out_ready does
// not hold results back. Each byte passes the input register, the single
// parser stage and the result register; the parser's bytewise CRC-32 update
// and status compares fit between the two registers.
// Header: magic "ITLP", 16-bit version, 16-bit kind, 32-bit payload length,
// all big-endian, followed by the payload and a big-endian stored CRC-32 over
// every byte before it. Payload bytes come out as results with is_status low;
// the last byte gives exactly one status result and the parser then clears
// for the next file. Other bytes outside the payload window give no result. The
// input side keeps accepting while a result waits on out_ready, as long as
// the result register is free or the new byte makes no result. Write the
// expected version and kind only while no file is in flight.
// ----------------------------------------------------------------------------
module crc32_container_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	// byte input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic                            last_byte,
	// results
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            is_status,
	output logic [7:0]                      payload_byte,
	output logic [2:0]                      status_code,
	output logic [31:0]                     body_length,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [crcdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                     cfg_data
);

	crcdf_pkg::item_t   item_in, item_s1;
	crcdf_pkg::result_t res, res_q;
	logic               valid_s1;
	logic               res_valid;
	logic               take;
	logic               out_valid_q;
	logic [15:0]        exp_version_q;
	logic [15:0]        exp_kind_q;

	assign item_in.data = data_byte;
	assign item_in.last = last_byte;

	// Parser advances when the held byte makes no result or the result
	// register is empty or being drained this cycle.
	assign take = valid_s1 && (!res_valid || !out_valid_q || out_ready);

	crcdf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	crcdf_parser u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (take),
		.item        (item_s1),
		.exp_version (exp_version_q),
		.exp_kind    (exp_kind_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_status    = res_q.is_status;
	assign payload_byte = res_q.payload_byte;
	assign status_code  = res_q.status_code;
	assign body_length  = res_q.body_length;

	// Configuration registers; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_version_q <= 16'd1;
			exp_kind_q    <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				crcdf_pkg::CFG_EXP_VERSION: exp_version_q <= cfg_data;
				crcdf_pkg::CFG_EXP_KIND:    exp_kind_q    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### sv/crcdf_checker.sv
// ----------------------------------------------------------------------------
// crcdf_checker: port-level assertions
// Result field rules and output hold behavior, bound to the top level.
// ----------------------------------------------------------------------------
module crcdf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_status,
	input logic [7:0]  payload_byte,
	input logic [2:0]  status_code,
	input logic [31:0] body_length
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_status) &&
		$stable(payload_byte) && $stable(status_code) && $stable(body_length))
		else $error("result changed while stalled");

	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> payload_byte == 8'd0)
		else $error("status result carries a payload byte");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_status |-> status_code == crcdf_pkg::ST_OK &&
		body_length == 32'd0)
		else $error("payload result carries status fields");

	a_err_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status && status_code != crcdf_pkg::ST_OK |->
		body_length == 32'd0)
		else $error("failed status reports a length");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status_code <= crcdf_pkg::ST_CRC)
		else $error("status code out of range");

endmodule

bind crc32_container_deframer crcdf_checker u_crcdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.is_status    (is_status),
	.payload_byte (payload_byte),
	.status_code  (status_code),
	.body_length  (body_length)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: container deframer with CRC-32 check
// Streams whole container files through crc32_container_deframer: directed
// files for each status first, then random files under several expected
// version and kind settings. A bytewise predictor tracks the header, the
// four-byte tail and the CRC, and every result is checked against it in order.
// ----------------------------------------------------------------------------

// Predictor and result store for the deframer
class container_scoreboard;
	logic [15:0] want_version;
	logic [15:0] want_kind;
	crcdf_pkg::pos_t bytes_seen;
	bit magic_ok;
	logic [15:0] hdr_version;
	logic [15:0] hdr_kind;
	logic [31:0] hdr_length;
	logic [31:0] crc_acc;
	logic [31:0] tail_word;
	crcdf_pkg::result_t pending_q[$];
	int unsigned mismatches;
	int unsigned bytes_in;
	int unsigned payload_count;
	int unsigned file_count;
	int unsigned status_count[8];

	function new();
		want_version = 16'd1;
		want_kind = 16'd0;
		mismatches = 0;
		bytes_in = 0;
		payload_count = 0;
		file_count = 0;
		foreach (status_count[i]) status_count[i] = 0;
		clear_file();
	endfunction

	function void clear_file();
		bytes_seen = '0;
		magic_ok = 1'b1;
		hdr_version = '0;
		hdr_kind = '0;
		hdr_length = '0;
		crc_acc = crcdf_pkg::CRC_ONES;
		tail_word = '0;
	endfunction

	// Reflected CRC-32, one byte, shift-and-mask form
	static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		int k;
		r = c ^ {24'd0, b};
		for (k = 0; k < 8; k++)
			r = (r >> 1) ^ (crcdf_pkg::CRC_POLY & {32{r[0]}});
		return r;
	endfunction

	static function logic [7:0] magic_at(logic [1:0] i);
		logic [31:0] w;
		w = 32'h4954_4C50; // "ITLP"
		return w[8*(3-i) +: 8];
	endfunction

	function void write_register(logic [7:0] idx, logic [15:0] value);
		if (idx == crcdf_pkg::CFG_EXP_VERSION)
			want_version = value;
		else if (idx == crcdf_pkg::CFG_EXP_KIND)
			want_kind = value;
	endfunction

	// One accepted input byte; queues the result it causes, if any
	function void note_byte(logic [7:0] b, logic last);
		crcdf_pkg::pos_t pos;
		crcdf_pkg::pos_t seen;
		crcdf_pkg::result_t r;
		logic [2:0] code;
		pos = bytes_seen;
		bytes_in++;
		if (pos < crcdf_pkg::POS_MAGIC_END) begin
			if (b != magic_at(pos[1:0]))
				magic_ok = 1'b0;
		end else if (pos < crcdf_pkg::POS_VER_END) begin
			hdr_version = {hdr_version[7:0], b};
		end else if (pos < crcdf_pkg::POS_KIND_END) begin
			hdr_kind = {hdr_kind[7:0], b};
		end else if (pos < crcdf_pkg::POS_HDR_END) begin
			hdr_length = {hdr_length[23:0], b};
		end
		// byte falling out of the four-byte tail enters the CRC
		if (pos >= crcdf_pkg::POS_MAGIC_END)
			crc_acc = crc_step(crc_acc, tail_word[31:24]);
		tail_word = {tail_word[23:0], b};
		seen = (pos == crcdf_pkg::POS_MAX) ? pos : pos + 1'b1;
		bytes_seen = seen;
		r = '0;
		if (!last) begin
			if (pos >= crcdf_pkg::POS_HDR_END &&
			    pos - crcdf_pkg::POS_HDR_END < crcdf_pkg::pos_t'(hdr_length)) begin
				r.payload_byte = b;
				pending_q.insert(pending_q.size(), r);
			end
			return;
		end
		if (seen < crcdf_pkg::POS_MIN_FILE)
			code = crcdf_pkg::ST_SHORT;
		else if (!magic_ok)
			code = crcdf_pkg::ST_MAGIC;
		else if (hdr_version != want_version)
			code = crcdf_pkg::ST_VERSION;
		else if (hdr_kind != want_kind)
			code = crcdf_pkg::ST_KIND;
		else if (crcdf_pkg::pos_t'(hdr_length) + crcdf_pkg::POS_MIN_FILE != seen)
			code = crcdf_pkg::ST_LENGTH;
		else if ((crc_acc ^ crcdf_pkg::CRC_ONES) != tail_word)
			code = crcdf_pkg::ST_CRC;
		else
			code = crcdf_pkg::ST_OK;
		r.is_status = 1'b1;
		r.status_code = code;
		r.body_length = (code == crcdf_pkg::ST_OK) ? hdr_length : '0;
		pending_q.insert(pending_q.size(), r);
		clear_file();
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task check_result(crcdf_pkg::result_t got);
		crcdf_pkg::result_t want;
		if (pending_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending: status=%b byte=%h code=%0d",
				got.is_status, got.payload_byte, got.status_code));
			return;
		end
		want = pending_q.pop_front();
		if (got.is_status !== want.is_status)
			report_mismatch($sformatf("is_status %b, want %b", got.is_status, want.is_status));
		if (got.payload_byte !== want.payload_byte)
			report_mismatch($sformatf("payload_byte %h, want %h",
				got.payload_byte, want.payload_byte));
		if (got.status_code !== want.status_code)
			report_mismatch($sformatf("status_code %0d, want %0d",
				got.status_code, want.status_code));
		if (got.body_length !== want.body_length)
			report_mismatch($sformatf("body_length %h, want %h",
				got.body_length, want.body_length));
		if (want.is_status) begin
			status_count[want.status_code]++;
			file_count++;
		end else begin
			payload_count++;
		end
	endtask
endclass

module testbench;

	localparam logic [31:0] MAGIC_TEXT   = 32'h4954_4C50; // "ITLP"
	localparam int          MAX_GAP      = 17;
	localparam int          HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int          SETTLE       = 4;    // margin for the input and result registers to drain
	localparam int          QUIET_LIMIT  = 4000; // cycles with no transfer at all
	localparam int          PHASE_BYTES  = 110;

	// Flavors of generated container files
	typedef enum {
		FR_GOOD, FR_SHORT, FR_MAGIC, FR_VERSION, FR_KIND, FR_LENGTH, FR_CRC, FR_NOISE
	} frame_flavor_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [7:0]                      data_byte = '0;
	logic                            last_byte = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            is_status;
	logic [7:0]                      payload_byte;
	logic [2:0]                      status_code;
	logic [31:0]                     body_length;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [crcdf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                     cfg_data = '0;

	container_scoreboard sb;

	logic [7:0]  frame_q[$];       // file being sent
	logic [15:0] cur_version = 16'd1;
	logic [15:0] cur_kind = 16'd0;
	int          pre_gap = 0;      // idle cycles before the next byte offer
	bit          steady = 1'b0;    // both sides run without idling
	bit          hold_request = 1'b0;
	int unsigned holds_done = 0;
	int unsigned cfg_writes = 0;
	int unsigned quiet_cycles = 0;

	crc32_container_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_status    (is_status),
		.payload_byte (payload_byte),
		.status_code  (status_code),
		.body_length  (body_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Payload bytes lean toward the all-zero and all-one extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Well-formed file layout with the given header fields; the CRC is always
	// computed over what was actually placed, so only header fields lie.
	function automatic void assemble(logic [15:0] ver, logic [15:0] knd,
			logic [31:0] hlen, int plen, bit extremes);
		logic [95:0] hdr;
		logic [31:0] crc;
		hdr = {MAGIC_TEXT, ver, knd, hlen};
		frame_q = {};
		for (int i = 0; i < 12; i++)
			frame_q.insert(frame_q.size(), hdr[95-8*i -: 8]);
		for (int i = 0; i < plen; i++)
			frame_q.insert(frame_q.size(),
				extremes ? ((i % 2) ? 8'hFF : 8'h00) : pick_byte());
		crc = crcdf_pkg::CRC_ONES;
		foreach (frame_q[i])
			crc = crcdf_pkg::crc_update(crc, frame_q[i]);
		crc = ~crc;
		for (int i = 0; i < 4; i++)
			frame_q.insert(frame_q.size(), crc[31-8*i -: 8]);
	endfunction

	// Builds one file of the given flavor. Error flavors sometimes carry a
	// lower-priority error too, so the priority order gets exercised.
	function automatic void build_frame(frame_flavor_t f, int plen);
		logic [15:0] ver;
		logic [15:0] knd;
		logic [31:0] hlen;
		int n;
		int idx;
		ver = cur_version;
		knd = cur_kind;
		hlen = plen;
		case (f)
			FR_MAGIC: begin
				if ($urandom_range(0, 1)) ver = ~ver;
			end
			FR_VERSION: begin
				ver = ver ^ 16'($urandom_range(1, 16'hFFFF));
				if ($urandom_range(0, 1)) knd = ~knd;
			end
			FR_KIND: begin
				knd = knd ^ 16'($urandom_range(1, 16'hFFFF));
				if ($urandom_range(0, 1)) hlen = hlen + 1;
			end
			FR_LENGTH: begin
				case ($urandom_range(0, 2))
					0:       hlen = 32'hFFFF_FFFF;
					1:       hlen = plen + $urandom_range(1, 3);
					default: hlen = (plen > 0) ? plen - 1 : 32'h8000_0000;
				endcase
			end
			default: ;
		endcase
		assemble(ver, knd, hlen, plen, 1'b0);
		case (f)
			FR_SHORT: begin
				n = $urandom_range(1, 15);
				while (frame_q.size() > n) void'(frame_q.pop_back());
			end
			FR_MAGIC: begin
				idx = $urandom_range(0, 3);
				frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
			end
			FR_CRC: begin
				// corrupt a payload or stored CRC byte, header left intact
				idx = $urandom_range(12, frame_q.size() - 1);
				frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
			end
			FR_NOISE: begin
				frame_q = {};
				n = $urandom_range(1, 40);
				repeat (n) frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endfunction

	// Half the files well-formed; the rest spread over every error and noise
	function automatic frame_flavor_t random_flavor();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) return FR_GOOD;
		if (sel < 56) return FR_SHORT;
		if (sel < 62) return FR_MAGIC;
		if (sel < 68) return FR_VERSION;
		if (sel < 74) return FR_KIND;
		if (sel < 82) return FR_LENGTH;
		if (sel < 90) return FR_CRC;
		return FR_NOISE;
	endfunction

	// One byte transfer. Valid stays high into the next byte when no gap is
	// drawn, so it is never lowered and raised in the same step.
	task automatic offer_byte(input logic [7:0] b, input logic l, input bit stop_after);
		repeat (pre_gap) @(posedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_byte(b, l);
		pre_gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (pre_gap != 0 || stop_after)
			in_valid <= 1'b0;
	endtask

	task automatic send_frame(input bit stop_after);
		int n;
		n = frame_q.size();
		for (int i = 0; i < n; i++)
			offer_byte(frame_q[i], i == n - 1, stop_after && i == n - 1);
	endtask

	// Sender pause: wait out every pending result, then the pipeline depth,
	// since bytes outside the payload window leave nothing to wait on.
	task automatic settle();
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_transfer(input logic [7:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.write_register(idx, value);
		cfg_writes++;
	endtask

	// Back-to-back register writes; a stray index goes first when asked
	task automatic configure(input logic [15:0] ver, input logic [15:0] knd, input bit stray);
		if (stray)
			cfg_transfer(8'($urandom_range(crcdf_pkg::CFG_EXP_KIND + 1, 255)),
				16'($urandom()));
		cfg_transfer(crcdf_pkg::CFG_EXP_VERSION, ver);
		cfg_transfer(crcdf_pkg::CFG_EXP_KIND, knd);
		cfg_valid <= 1'b0;
		cur_version = ver;
		cur_kind = knd;
	endtask

	// Random files until the phase has its share of bytes
	task automatic random_phase();
		int sent;
		int plen;
		bit stop;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 8);
			build_frame(random_flavor(), plen);
			steady = ($urandom_range(0, 3) == 0);
			stop = (sent + frame_q.size() >= PHASE_BYTES);
			sent += frame_q.size();
			send_frame(stop);
		end
		steady = 1'b0;
	endtask

	// Result side: random stalls per transfer, one long hold-off on request
	initial begin
		int stall;
		crcdf_pkg::result_t got;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = steady ? 0 : $urandom_range(0, MAX_GAP);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			got = {is_status, payload_byte, status_code, body_length};
			sb.check_result(got);
		end
	end

	// Watchdog: a run with no transfer of any kind for too long is hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("watchdog: no transfer in %0d cycles, %0d results pending",
					QUIET_LIMIT, sb.pending_q.size());
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed files under the reset values of the registers.
		// one-byte file: too short
		frame_q = {8'hFF};
		send_frame(1'b0);
		// fifteen bytes of a valid file: one short of the minimum
		assemble(cur_version, cur_kind, 0, 0, 1'b0);
		void'(frame_q.pop_back());
		send_frame(1'b0);
		// minimal good file, empty payload
		build_frame(FR_GOOD, 0);
		send_frame(1'b0);
		// good file, payload of extreme byte values
		assemble(cur_version, cur_kind, 4, 4, 1'b1);
		send_frame(1'b0);
		build_frame(FR_MAGIC, 1);
		send_frame(1'b0);
		build_frame(FR_VERSION, 1);
		send_frame(1'b0);
		build_frame(FR_KIND, 1);
		send_frame(1'b0);
		build_frame(FR_CRC, 1);
		send_frame(1'b0);
		// header length far past the file: last byte lands in the payload window
		assemble(cur_version, cur_kind, 32'hFFFF_FFFF, 4, 1'b0);
		send_frame(1'b1);
		settle();

		// Back-pressure: long receiver hold-off while bytes keep coming
		hold_request = 1'b1;
		steady = 1'b1;
		build_frame(FR_GOOD, 48);
		send_frame(1'b0);
		random_phase();
		settle();

		// Register extremes, then random settings; stray writes on the way
		configure(16'h0000, 16'hFFFF, 1'b1);
		random_phase();
		settle();
		configure(16'hFFFF, 16'h0000, 1'b0);
		random_phase();
		settle();
		configure(16'($urandom()), 16'($urandom()), 1'b1);
		random_phase();
		settle();
		configure(16'($urandom()), 16'($urandom()), 1'b0);
		random_phase();
		settle();

		$display("run: %0d bytes in over %0d files, %0d payload bytes out,",
			sb.bytes_in, sb.file_count, sb.payload_count);
		$display("     %0d register writes, %0d long holds; statuses: ok %0d short %0d",
			cfg_writes, holds_done, sb.status_count[crcdf_pkg::ST_OK],
			sb.status_count[crcdf_pkg::ST_SHORT]);
		$display("     magic %0d version %0d kind %0d length %0d crc %0d",
			sb.status_count[crcdf_pkg::ST_MAGIC], sb.status_count[crcdf_pkg::ST_VERSION],
			sb.status_count[crcdf_pkg::ST_KIND], sb.status_count[crcdf_pkg::ST_LENGTH],
			sb.status_count[crcdf_pkg::ST_CRC]);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
